FILE: hw/rtl/top_k_farthest_from_origin_unit_macros.svh
// Assertion macros shared by the farthest-point selection RTL.
`ifndef TOP_K_FARTHEST_FROM_ORIGIN_UNIT_MACROS_SVH
`define TOP_K_FARTHEST_FROM_ORIGIN_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/tkf_pkg.sv
// Package with the types and constants of the farthest-point selection block.
package tkf_pkg;

   localparam int KEEP_COUNT_DEF = 10;
   localparam int COORD_W        = 11;
   localparam int DIST_W         = 23;
   localparam int RANK_W         = 4;
   localparam int REQ_TDATA_W    = 24;
   localparam int RSP_TDATA_W    = 56;

   localparam logic [COORD_W-1:0] COORD_LIMIT = 11'd2000;

   typedef struct packed {
      logic              vld;
      logic [DIST_W-1:0]  dist_sq;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } slot_type;

   typedef struct packed {
      logic     vld;
      logic     last;
      slot_type pnt;
   } point_type;

   typedef struct packed {
      logic ins;
      logic drain;
   } cell_ctl_type;

endpackage

FILE: hw/rtl/tkf_dist.sv
// Input stage that clamps an out-of-range point to the origin and registers its squared distance.
module tkf_dist
   import tkf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [COORD_W-1:0] x_coord,
   input  logic [COORD_W-1:0] y_coord,
   input  logic               last_point,
   output point_type          pt
);

   logic               far;
   logic [COORD_W-1:0] x_c;
   logic [COORD_W-1:0] y_c;
   logic [DIST_W-1:0]  xx;
   logic [DIST_W-1:0]  yy;
   logic               vld_ff;
   logic               vld_in;
   point_type          pt_ff;
   point_type          pt_in;

   assign far = (x_coord > COORD_LIMIT) || (y_coord > COORD_LIMIT);
   assign x_c = far ? '0 : x_coord;
   assign y_c = far ? '0 : y_coord;
   assign xx  = DIST_W'(x_c) * DIST_W'(x_c);
   assign yy  = DIST_W'(y_c) * DIST_W'(y_c);

   always_comb begin
      vld_in       = take;
      pt_in        = pt_ff;
      if (take) begin
         pt_in.last        = last_point;
         pt_in.pnt.x       = x_c;
         pt_in.pnt.y       = y_c;
         pt_in.pnt.dist_sq = DIST_W'(xx + yy);
         pt_in.pnt.vld     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      pt_ff <= pt_in;
   end

   always_comb begin
      pt     = pt_ff;
      pt.vld = vld_ff;
   end

endmodule

FILE: hw/rtl/tkf_cell.sv
// One slot of the sorted store, which inserts, shifts down or drains.
module tkf_cell
   import tkf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  slot_type     cand,
   input  slot_type     upper,
   input  logic         upper_le,
   output slot_type     slot,
   output logic         le
);

   slot_type slot_ff;
   slot_type slot_in;

   assign le = (slot_ff.dist_sq <= cand.dist_sq);

   always_comb begin
      slot_in = slot_ff;
      if (ctl.drain) begin
         slot_in = upper;
      end else if (ctl.ins) begin
         if (upper_le) begin
            slot_in = upper;
         end else if (le) begin
            slot_in = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

FILE: hw/rtl/top_k_farthest_from_origin_unit.sv
// Top level of the block that keeps the points farthest from the origin.
//
// Points arrive on the req_ channel, one per transaction, with req_tlast on the
// final point of a set. A point with a coordinate above 2000 counts as the origin.
// Each point's squared distance is registered in the input stage and then placed in
// a row of KEEP_COUNT cells sorted ascending, so points are taken one per cycle
// while req_tready is high. When the final point has been placed, the row drains
// toward cell 0 and one transaction per slot leaves on the rsp_ channel, smallest
// first, the last with rsp_tlast. The first slot is offered once the final point is
// registered, the state has turned to drain and the slot is in the output register.
// req_tready is low from the acceptance of the final point until the last slot has
// been loaded into the output register. Draining feeds empty slots in at the top, so
// the store is empty again afterwards. A stall on rsp_tready holds the output
// register and pauses the drain. Reset empties the store and the output register.
module top_k_farthest_from_origin_unit
   import tkf_pkg::*;
#(
   parameter int KEEP_COUNT = KEEP_COUNT_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // x_coord [10:0], y_coord [21:11], zero [23:22].
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_x [10:0], out_y [21:11], out_dist_sq [44:22], slot_rank [48:45], zero [55:49].
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // slot_valid [0].
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

`include "top_k_farthest_from_origin_unit_macros.svh"

   localparam int CNT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(KEEP_COUNT - 1);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             take;
   logic             drain_go;
   point_type        pt;
   cell_ctl_type     ctl;
   slot_type         slots [0:KEEP_COUNT];
   logic [KEEP_COUNT:0] les;

   logic              rsp_vld_ff;
   logic              rsp_vld_in;
   slot_type          rsp_slot_ff;
   slot_type          rsp_slot_in;
   logic [RANK_W-1:0] rsp_rank_ff;
   logic [RANK_W-1:0] rsp_rank_in;
   logic              rsp_end_ff;
   logic              rsp_end_in;

   assign req_tready = (state_ff == ST_RUN) && !(pt.vld && pt.last);
   assign take       = req_tvalid && req_tready;

   tkf_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .x_coord    (req_tdata[COORD_W-1:0]),
      .y_coord    (req_tdata[2*COORD_W-1:COORD_W]),
      .last_point (req_tlast),
      .pt         (pt)
   );

   assign drain_go  = (state_ff == ST_DRAIN) && (!rsp_vld_ff || rsp_tready);
   assign ctl.drain = drain_go;
   assign ctl.ins   = pt.vld && (pt.pnt.dist_sq > slots[0].dist_sq);

   assign slots[KEEP_COUNT] = '0;
   assign les[KEEP_COUNT]   = 1'b0;

   for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
      tkf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cand     (pt.pnt),
         .upper    (slots[i+1]),
         .upper_le (les[i+1]),
         .slot     (slots[i]),
         .le       (les[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (pt.vld && pt.last) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end
         end
         ST_DRAIN: begin
            if (drain_go) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_END) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_rank_in = rsp_rank_ff;
      rsp_end_in  = rsp_end_ff;
      if (drain_go) begin
         rsp_vld_in  = 1'b1;
         rsp_slot_in = slots[0];
         rsp_rank_in = RANK_W'(cnt_ff);
         rsp_end_in  = (cnt_ff == CNT_END);
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_slot_ff <= rsp_slot_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, rsp_rank_ff, rsp_slot_ff.dist_sq, rsp_slot_ff.y, rsp_slot_ff.x};
   assign rsp_tuser  = rsp_slot_ff.vld;
   assign rsp_tlast  = rsp_end_ff;

   `TKF_ASSERT_NEXT(a_last_starts_drain, clock, reset, pt.vld && pt.last,
      state_ff == ST_DRAIN, "Final point did not start the drain.")
   `TKF_ASSERT_SAME(a_drain_input_empty, clock, reset, state_ff == ST_DRAIN,
      !pt.vld, "Input stage holds a point during the drain.")
   `TKF_ASSERT_NEXT(a_drain_clears_top, clock, reset, drain_go && (cnt_ff == CNT_END),
      !slots[KEEP_COUNT-1].vld && (state_ff == ST_RUN), "Store not empty after the drain.")
   `TKF_ASSERT_SAME(a_end_rank, clock, reset, rsp_vld_ff && rsp_end_ff,
      rsp_rank_ff == RANK_W'(KEEP_COUNT - 1), "Final slot carries the wrong rank.")

endmodule
